// ===== rtl/tqm_pkg.sv =====
// Shared types and constants for the timer queue manager.
// Used by timer_queue_manager_core; depends on nothing.
package tqm_pkg;

  // Timer table size and emission limit per tick
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned MAX_OUT = 16;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned K_W   = $clog2(MAX_OUT + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [K_W-1:0]   k_t;

  // One table entry; age is the dense insertion rank (0 = oldest)
  typedef struct packed {
    logic [31:0]      deadline;
    logic [15:0]      id;
    logic [15:0]      tag;
    logic [IDX_W-1:0] age;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_CANCEL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_SET_ACK    = 2'd0,
    KIND_CANCEL_ACK = 2'd1,
    KIND_EXPIRED    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_EN    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // What a table pass looks for
  typedef enum logic [1:0] {
    MODE_EXPIRE,
    MODE_CANCEL,
    MODE_SWEEP
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_PSTART,
    S_PASS,
    S_PEND,
    S_EMIT
  } state_e;

endpackage

// ===== rtl/timer_queue_manager_core.sv =====
// Timer queue manager core: table of pending timers, set / cancel / tick items.
// Depends on tqm_pkg and tqm_ram.
//
// The block holds up to DEPTH timers in a RAM (deadline, id, tag, insertion
// rank) with valid bits and a fill count in flops. One item is worked at a
// time; in_stall_o is high until the item's last result has been loaded into
// the output register. All table passes run through a single comparator
// that walks the RAM one entry per cycle. A set scans the valid bits for
// the first free slot and writes the entry there; a rejected set is
// answered without a scan. A cancel runs one pass per matching entry,
// dropping one each time, and a final pass that finds none. A tick while
// enabled runs one pass per expiring timer and a final one (at most MAX_OUT
// expiring per tick, earliest deadline first, ties oldest first); a tick
// while disabled, or an unused op code, gives no result. A stalled output
// delays every result after the first. The output register is separate,
// so a result may sit stalled while the next item is being worked, as long
// as that item has not reached its own result.
// Deadlines are compared as a signed 32-bit difference from the current
// time, so time wrap is handled. No clearing pass is needed after reset.
module timer_queue_manager_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [23:0] duration_i,
  input  logic [15:0] tag_i,
  input  logic [15:0] cancel_id_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [1:0]  status_o,
  output logic [15:0] result_id_o,
  output logic [15:0] tag_out_o,
  output logic        pending_o,
  output logic        last_o
);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  tqm_pkg::state_e state_q, state_d;
  tqm_pkg::mode_e  mode_q, mode_d;

  logic                   enable_q;
  logic [tqm_pkg::DEPTH-1:0] valid_q, valid_d;
  tqm_pkg::cnt_t          cnt_q, cnt_d;
  logic [31:0]            now_q, now_d;
  logic [15:0]            next_id_q, next_id_d;

  // latched item fields
  logic [23:0]            duration_q, duration_d;
  logic [15:0]            tag_q, tag_d;
  logic [15:0]            cid_q, cid_d;

  // pass sequencing
  logic [tqm_pkg::IDX_W:0] iss_q, iss_d;     // read issue / free-slot scan
  logic                   chk_vld_q, chk_vld_d;
  tqm_pkg::idx_t          chk_idx_q, chk_idx_d;

  // best candidate of the current pass
  logic                   hit_q, hit_d;
  logic [31:0]            bkey_q, bkey_d;
  tqm_pkg::idx_t          hidx_q, hidx_d;
  tqm_pkg::idx_t          hage_q, hage_d;
  logic [15:0]            hid_q, hid_d;
  logic [15:0]            htag_q, htag_d;

  // rank fix-up owed by the previous drop, applied during the next pass
  logic                   dec_pend_q, dec_pend_d;
  tqm_pkg::idx_t          dec_age_q, dec_age_d;

  // expiry held back until we know whether it is the last one
  logic                   held_q, held_d;
  logic [15:0]            held_id_q, held_id_d;
  logic [15:0]            held_tag_q, held_tag_d;
  logic                   held_pend_q, held_pend_d;
  tqm_pkg::k_t            k_q, k_d;
  logic                   found_q, found_d;

  // staged result and what follows it
  tqm_pkg::kind_e         res_kind_q, res_kind_d;
  tqm_pkg::status_e       res_status_q, res_status_d;
  logic [15:0]            res_id_q, res_id_d;
  logic [15:0]            res_tag_q, res_tag_d;
  logic                   res_pend_q, res_pend_d;
  logic                   res_last_q, res_last_d;
  logic                   more_q, more_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  tqm_pkg::kind_e         out_kind_q;
  tqm_pkg::status_e       out_status_q;
  logic [15:0]            out_id_q;
  logic [15:0]            out_tag_q;
  logic                   out_pend_q;
  logic                   out_last_q;

  // ---------------------------------------------------------------------
  // Table RAM
  // ---------------------------------------------------------------------
  logic                          ram_we;
  tqm_pkg::idx_t                 ram_waddr;
  tqm_pkg::entry_t               ram_wdata;
  logic                          ram_re;
  logic [tqm_pkg::ENTRY_W-1:0]   ram_rdata;

  tqm_ram #(
    .Width (tqm_pkg::ENTRY_W),
    .Depth (tqm_pkg::DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (iss_q[tqm_pkg::IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Shared compare unit: looks at the entry read back this cycle
  // ---------------------------------------------------------------------
  tqm_pkg::entry_t ent;
  logic            ent_v;
  tqm_pkg::idx_t   age_adj;
  logic            age_wb;
  logic [31:0]     diff;
  logic            due;
  logic [31:0]     key;
  logic            better;
  logic            exp_take;
  logic            can_take;
  logic            pass_last;

  logic            in_acc;
  logic            out_free;
  logic            slot_free;
  logic            tbl_full;
  tqm_pkg::op_e    op_in;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign slot_free = !valid_q[iss_q[tqm_pkg::IDX_W-1:0]];
  assign tbl_full  = (cnt_q == tqm_pkg::CNT_W'(tqm_pkg::DEPTH));
  assign op_in     = tqm_pkg::op_e'(op_i);

  assign ent    = tqm_pkg::entry_t'(ram_rdata);
  assign ent_v  = chk_vld_q && valid_q[chk_idx_q];
  // ranks above the one just dropped close the gap
  assign age_wb = ent_v && dec_pend_q && (ent.age > dec_age_q);
  assign age_adj = age_wb ? ent.age - 1'b1 : ent.age;

  // due when the signed distance to the deadline is zero or negative;
  // flipping the sign bit orders the due ones earliest first
  assign diff   = ent.deadline - now_q;
  assign due    = (diff == 32'd0) || diff[31];
  assign key    = {~diff[31], diff[30:0]};
  assign better = !hit_q || (key < bkey_q) || ((key == bkey_q) && (age_adj < hage_q));

  assign exp_take = (mode_q == tqm_pkg::MODE_EXPIRE) && ent_v && due && better;
  assign can_take = (mode_q == tqm_pkg::MODE_CANCEL) && ent_v && (ent.id == cid_q) && !hit_q;

  assign pass_last = chk_vld_q && (chk_idx_q == tqm_pkg::IDX_W'(tqm_pkg::DEPTH - 1));

  assign in_stall_o = (state_q != tqm_pkg::S_IDLE);

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tqm_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (op_in)
            tqm_pkg::OP_TICK:   state_d = enable_q ? tqm_pkg::S_PSTART : tqm_pkg::S_IDLE;
            tqm_pkg::OP_SET:    state_d = (!enable_q || tbl_full) ? tqm_pkg::S_EMIT
                                                                  : tqm_pkg::S_FREE;
            tqm_pkg::OP_CANCEL: state_d = tqm_pkg::S_PSTART;
            default:            state_d = tqm_pkg::S_IDLE;
          endcase
        end
      end
      tqm_pkg::S_FREE: begin
        if (slot_free) begin
          state_d = tqm_pkg::S_EMIT;
        end
      end
      tqm_pkg::S_PSTART: state_d = tqm_pkg::S_PASS;
      tqm_pkg::S_PASS: begin
        if (pass_last) begin
          state_d = tqm_pkg::S_PEND;
        end
      end
      tqm_pkg::S_PEND: begin
        unique case (mode_q)
          tqm_pkg::MODE_CANCEL: state_d = hit_q ? tqm_pkg::S_PSTART : tqm_pkg::S_EMIT;
          tqm_pkg::MODE_EXPIRE: begin
            if (held_q) begin
              state_d = tqm_pkg::S_EMIT;
            end else begin
              state_d = hit_q ? tqm_pkg::S_PSTART : tqm_pkg::S_IDLE;
            end
          end
          tqm_pkg::MODE_SWEEP:  state_d = tqm_pkg::S_EMIT;
          default:              state_d = tqm_pkg::S_IDLE;
        endcase
      end
      tqm_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = more_q ? tqm_pkg::S_PSTART : tqm_pkg::S_IDLE;
        end
      end
      default: state_d = tqm_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath and outputs of the sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    mode_d       = mode_q;
    valid_d      = valid_q;
    cnt_d        = cnt_q;
    now_d        = now_q;
    next_id_d    = next_id_q;
    duration_d   = duration_q;
    tag_d        = tag_q;
    cid_d        = cid_q;
    iss_d        = iss_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    hit_d        = hit_q;
    bkey_d       = bkey_q;
    hidx_d       = hidx_q;
    hage_d       = hage_q;
    hid_d        = hid_q;
    htag_d       = htag_q;
    dec_pend_d   = dec_pend_q;
    dec_age_d    = dec_age_q;
    held_d       = held_q;
    held_id_d    = held_id_q;
    held_tag_d   = held_tag_q;
    held_pend_d  = held_pend_q;
    k_d          = k_q;
    found_d      = found_q;
    res_kind_d   = res_kind_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_tag_d    = res_tag_q;
    res_pend_d   = res_pend_q;
    res_last_d   = res_last_q;
    more_d       = more_q;
    ram_we       = 1'b0;
    ram_waddr    = chk_idx_q;
    ram_wdata    = ent;
    ram_re       = 1'b0;

    unique case (state_q)
      tqm_pkg::S_IDLE: begin
        if (in_acc) begin
          duration_d = duration_i;
          tag_d      = tag_i;
          cid_d      = cancel_id_i;
          iss_d      = '0;
          held_d     = 1'b0;
          k_d        = '0;
          found_d    = 1'b0;
          more_d     = 1'b0;
          unique case (op_in)
            tqm_pkg::OP_TICK: begin
              now_d  = now_q + 32'd1;
              mode_d = tqm_pkg::MODE_EXPIRE;
            end
            tqm_pkg::OP_SET: begin
              // rejected sets are answered straight away
              res_kind_d   = tqm_pkg::KIND_SET_ACK;
              res_status_d = enable_q ? tqm_pkg::ST_FULL : tqm_pkg::ST_NOT_EN;
              res_id_d     = 16'd0;
              res_tag_d    = 16'd0;
              res_pend_d   = (cnt_q != '0);
              res_last_d   = 1'b1;
            end
            tqm_pkg::OP_CANCEL: mode_d = tqm_pkg::MODE_CANCEL;
            default: ;
          endcase
        end
      end

      tqm_pkg::S_FREE: begin
        if (slot_free) begin
          ram_we       = 1'b1;
          ram_waddr    = iss_q[tqm_pkg::IDX_W-1:0];
          ram_wdata    = '{deadline: now_q + {8'd0, duration_q},
                           id:       next_id_q,
                           tag:      tag_q,
                           age:      cnt_q[tqm_pkg::IDX_W-1:0]};
          valid_d[iss_q[tqm_pkg::IDX_W-1:0]] = 1'b1;
          cnt_d        = cnt_q + 1'b1;
          next_id_d    = next_id_q + 16'd1;
          res_kind_d   = tqm_pkg::KIND_SET_ACK;
          res_status_d = tqm_pkg::ST_OK;
          res_id_d     = next_id_q;
          res_tag_d    = 16'd0;
          res_pend_d   = 1'b1;
          res_last_d   = 1'b1;
          more_d       = 1'b0;
        end else begin
          iss_d = iss_q + 1'b1;
        end
      end

      tqm_pkg::S_PSTART: begin
        iss_d = '0;
        hit_d = 1'b0;
      end

      tqm_pkg::S_PASS: begin
        // issue side
        if (iss_q < (tqm_pkg::IDX_W + 1)'(tqm_pkg::DEPTH)) begin
          ram_re    = 1'b1;
          iss_d     = iss_q + 1'b1;
          chk_vld_d = 1'b1;
          chk_idx_d = iss_q[tqm_pkg::IDX_W-1:0];
        end
        // check side
        if (age_wb) begin
          ram_we    = 1'b1;
          ram_waddr = chk_idx_q;
          ram_wdata = '{deadline: ent.deadline, id: ent.id, tag: ent.tag, age: age_adj};
        end
        if (exp_take || can_take) begin
          hit_d  = 1'b1;
          bkey_d = key;
          hidx_d = chk_idx_q;
          hage_d = age_adj;
          hid_d  = ent.id;
          htag_d = ent.tag;
        end
      end

      tqm_pkg::S_PEND: begin
        // the pass settled any owed fix-up; a new drop owes the next one
        dec_pend_d = hit_q;
        dec_age_d  = hage_q;
        if (hit_q) begin
          valid_d[hidx_q] = 1'b0;
          cnt_d           = cnt_q - 1'b1;
        end
        unique case (mode_q)
          tqm_pkg::MODE_CANCEL: begin
            if (hit_q) begin
              found_d = 1'b1;
            end else begin
              res_kind_d   = tqm_pkg::KIND_CANCEL_ACK;
              res_status_d = found_q ? tqm_pkg::ST_OK : tqm_pkg::ST_NOT_FOUND;
              res_id_d     = cid_q;
              res_tag_d    = 16'd0;
              res_pend_d   = (cnt_q != '0);
              res_last_d   = 1'b1;
              more_d       = 1'b0;
            end
          end
          tqm_pkg::MODE_EXPIRE: begin
            if (held_q) begin
              res_kind_d   = tqm_pkg::KIND_EXPIRED;
              res_status_d = tqm_pkg::ST_OK;
              res_id_d     = held_id_q;
              res_tag_d    = held_tag_q;
              res_pend_d   = held_pend_q;
              res_last_d   = !hit_q;
              more_d       = hit_q;
            end
            if (hit_q) begin
              held_d      = 1'b1;
              held_id_d   = hid_q;
              held_tag_d  = htag_q;
              held_pend_d = (cnt_q != tqm_pkg::CNT_W'(1));
              k_d         = k_q + 1'b1;
              // limit reached: one more pass only to close the rank gap
              if (k_q == tqm_pkg::K_W'(tqm_pkg::MAX_OUT - 1)) begin
                mode_d = tqm_pkg::MODE_SWEEP;
              end
            end else begin
              held_d = 1'b0;
            end
          end
          tqm_pkg::MODE_SWEEP: begin
            res_kind_d   = tqm_pkg::KIND_EXPIRED;
            res_status_d = tqm_pkg::ST_OK;
            res_id_d     = held_id_q;
            res_tag_d    = held_tag_q;
            res_pend_d   = held_pend_q;
            res_last_d   = 1'b1;
            more_d       = 1'b0;
            held_d       = 1'b0;
          end
          default: ;
        endcase
      end

      tqm_pkg::S_EMIT: ;

      default: ;
    endcase
  end

  // output register load
  logic out_load;
  assign out_load = (state_q == tqm_pkg::S_EMIT) && out_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tqm_pkg::S_IDLE;
      mode_q      <= tqm_pkg::MODE_EXPIRE;
      enable_q    <= 1'b0;
      valid_q     <= '0;
      cnt_q       <= '0;
      now_q       <= '0;
      next_id_q   <= '0;
      iss_q       <= '0;
      chk_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      dec_pend_q  <= 1'b0;
      held_q      <= 1'b0;
      k_q         <= '0;
      found_q     <= 1'b0;
      more_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      now_q       <= now_d;
      next_id_q   <= next_id_d;
      iss_q       <= iss_d;
      chk_vld_q   <= chk_vld_d;
      hit_q       <= hit_d;
      dec_pend_q  <= dec_pend_d;
      held_q      <= held_d;
      k_q         <= k_d;
      found_q     <= found_d;
      more_q      <= more_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    duration_q   <= duration_d;
    tag_q        <= tag_d;
    cid_q        <= cid_d;
    chk_idx_q    <= chk_idx_d;
    bkey_q       <= bkey_d;
    hidx_q       <= hidx_d;
    hage_q       <= hage_d;
    hid_q        <= hid_d;
    htag_q       <= htag_d;
    dec_age_q    <= dec_age_d;
    held_id_q    <= held_id_d;
    held_tag_q   <= held_tag_d;
    held_pend_q  <= held_pend_d;
    res_kind_q   <= res_kind_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_tag_q    <= res_tag_d;
    res_pend_q   <= res_pend_d;
    res_last_q   <= res_last_d;
    if (out_load) begin
      out_kind_q   <= res_kind_q;
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_tag_q    <= res_tag_q;
      out_pend_q   <= res_pend_q;
      out_last_q   <= res_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign status_o    = out_status_q;
  assign result_id_o = out_id_q;
  assign tag_out_o   = out_tag_q;
  assign pending_o   = out_pend_q;
  assign last_o      = out_last_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // fill count tracks the valid bits
  a_cnt_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == tqm_pkg::CNT_W'($countones(valid_q)))
    else $error("fill count out of step with valid bits");

  // an idle block owes no rank fix-up and holds no expiry
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tqm_pkg::S_IDLE |-> !dec_pend_q && !held_q)
    else $error("work left over at idle");

  // free-slot search only starts with room in the table
  a_free_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tqm_pkg::S_FREE |-> cnt_q < tqm_pkg::CNT_W'(tqm_pkg::DEPTH))
    else $error("free-slot search on a full table");

  // a tick item advances time by one
  a_tick_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && op_i == tqm_pkg::OP_TICK |=> now_q == $past(now_q) + 32'd1)
    else $error("time did not advance on tick");

  // a result is only loaded when the output register can take it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> $stable(out_id_q) && $stable(out_last_q))
    else $error("stalled result overwritten");

endmodule

// ===== rtl/tqm_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module tqm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
